### hw/rtl/gbs_pkg.sv
package gbs_pkg;

  // Block geometry.
  localparam int NUM_BANDS    = 8;
  localparam int BLOCK_FRAMES = 16;

  localparam int BAND_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int FRAME_W = $clog2(BLOCK_FRAMES + 1);

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int X_W      = 12;  // sample after the arithmetic shift by 4
  localparam int STATE_W  = 32;
  localparam int COEF_W   = 17;
  localparam int PROD_W   = COEF_W + STATE_W;
  localparam int MAG_W    = 15;
  localparam int IDX_W    = 3;
  localparam int CHAN_W   = 2;
  localparam int COEF_SHIFT = 15;

  // Channel mode codes.
  localparam logic [CHAN_W-1:0] CHAN_MONO   = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_STEREO = 2'd2;

  localparam logic [MAG_W-1:0] MAG_MAX = 15'h7fff;

  // Q15 Goertzel coefficients, 2*cos(w) scaled by 32768.
  localparam logic signed [COEF_W-1:0] BAND_COEF [8] = '{
    17'sd60547, 17'sd46341, 17'sd25080, 17'sd0,
    -17'sd25080, -17'sd46341, -17'sd60547, -17'sd65536
  };

  // Band b uses coefficient entry b mod 8.
  function automatic logic signed [COEF_W-1:0] coef_of(input logic [BAND_W-1:0] band);
    logic [2:0] k;
    k = 3'(band);
    return BAND_COEF[k];
  endfunction

  // One RAM word holds s1 in the upper half and s2 in the lower half.
  typedef struct packed {
    logic [STATE_W-1:0] recent;
    logic [STATE_W-1:0] older;
  } band_state_t;

  localparam int WORD_W = 2 * STATE_W;

endpackage

### hw/rtl/gbs_ram.sv
module gbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/goertzel_band_spectrum.sv
// Channel   Direction  Handshake            Payload
// config    in         config_write         config_data (channel_count)
// in        in         in_valid / in_stall  left_sample, right_sample, chunk_start
// out       out        out_valid / out_stall band_index, band_magnitude, last_band
//
// In a counted frame one band state is read from the state RAM per cycle,
// multiplied into the product register and written back, and the next frame
// waits until the last band has been written. Frames that are ignored start
// no update sweep. The final frame of a block is followed by an output sweep
// that takes each band through the read, magnitude and output register steps.
// Reset (rst, synchronous) marks every band state as zero, sets the block idle
// until a chunk starts and selects stereo; no clearing pass is needed.
// A stall on the output only holds the output register and the sweep.
module goertzel_band_spectrum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 config_write,
  input  logic [gbs_pkg::CHAN_W-1:0]           config_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gbs_pkg::SAMPLE_W-1:0]  left_sample,
  input  logic signed [gbs_pkg::SAMPLE_W-1:0]  right_sample,
  input  logic                                 chunk_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [gbs_pkg::IDX_W-1:0]            band_index,
  output logic [gbs_pkg::MAG_W-1:0]            band_magnitude,
  output logic                                 last_band
);

  localparam logic [gbs_pkg::BAND_W-1:0] LAST_BAND =
    gbs_pkg::BAND_W'(gbs_pkg::NUM_BANDS - 1);
  localparam logic [gbs_pkg::FRAME_W-1:0] FRAMES_END =
    gbs_pkg::FRAME_W'(gbs_pkg::BLOCK_FRAMES);

  // The sequencer: idle, band update sweep, then, after a block's final frame, the output sweep.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_UPD   = 5'b00010,
    S_E_RD  = 5'b00100,
    S_E_ABS = 5'b01000,
    S_E_OUT = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [gbs_pkg::CHAN_W-1:0]  channel_count;
  logic [gbs_pkg::FRAME_W-1:0] frame_index;
  logic [gbs_pkg::NUM_BANDS-1:0] band_valid;
  logic                          emit_pending;
  logic signed [gbs_pkg::X_W-1:0] x;

  // Band counters and pipeline tags.
  logic [gbs_pkg::BAND_W-1:0] rd_band;
  logic                       issue_done;
  logic                       v1;
  logic [gbs_pkg::BAND_W-1:0] b1;
  logic                       v2;
  logic [gbs_pkg::BAND_W-1:0] b2;

  logic signed [gbs_pkg::PROD_W-1:0] prod;
  logic [gbs_pkg::STATE_W-1:0]       s1_q;
  logic [gbs_pkg::STATE_W-1:0]       s2_q;
  logic [gbs_pkg::STATE_W-1:0]       abs1;
  logic [gbs_pkg::STATE_W-1:0]       abs2;

  // RAM ports.
  logic                         rd_en;
  logic                         wr_en;
  logic [gbs_pkg::WORD_W-1:0]   rd_word;
  gbs_pkg::band_state_t         rd_data;
  gbs_pkg::band_state_t         wr_data;

  gbs_ram #(
    .WIDTH (gbs_pkg::WORD_W),
    .DEPTH (gbs_pkg::NUM_BANDS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (b2),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_band),
    .rdata (rd_word)
  );

  // An entry that has not been written since the chunk started reads as zero.
  always_comb begin
    rd_data = gbs_pkg::band_state_t'(rd_word);
    if (!band_valid[b1]) begin
      rd_data = '0;
    end
  end

  // Input request handling: the sample reduction happens at acceptance.
  logic                               in_take;
  logic [gbs_pkg::FRAME_W-1:0]        frame_eff;
  logic                               frame_counted;
  logic signed [gbs_pkg::SAMPLE_W:0]  pair_sum;
  logic signed [gbs_pkg::SAMPLE_W:0]  pair_adj;
  logic signed [gbs_pkg::SAMPLE_W-1:0] mixed;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    frame_eff     = chunk_start ? '0 : frame_index;
    frame_counted = (frame_eff < FRAMES_END);
    pair_sum      = $signed({left_sample[gbs_pkg::SAMPLE_W-1], left_sample}) +
                    $signed({right_sample[gbs_pkg::SAMPLE_W-1], right_sample});
    // Truncating toward zero: odd negative sums are rounded up before the shift.
    pair_adj      = pair_sum + ((pair_sum[gbs_pkg::SAMPLE_W] && pair_sum[0]) ?
                    (gbs_pkg::SAMPLE_W+1)'(1) : '0);
    if (channel_count == gbs_pkg::CHAN_STEREO) begin
      mixed = pair_adj[gbs_pkg::SAMPLE_W:1];
    end else begin
      mixed = left_sample;
    end
  end

  // Update datapath: s0 = x + ((coef * s1) >>> 15) - s2, wrapped to 32 bits.
  logic [gbs_pkg::STATE_W-1:0] s0;
  assign s0 = gbs_pkg::STATE_W'($signed(x)) +
              prod[gbs_pkg::COEF_SHIFT +: gbs_pkg::STATE_W] - s2_q;
  assign wr_en   = v2;
  assign wr_data = '{recent: s0, older: s1_q};

  // Magnitude: 2*(|s1|+|s2|) saturated.
  logic [gbs_pkg::STATE_W+1:0] mag_full;
  logic [gbs_pkg::MAG_W-1:0]   mag;
  assign mag_full = {(gbs_pkg::STATE_W+1)'(abs1) + (gbs_pkg::STATE_W+1)'(abs2), 1'b0};
  assign mag = (mag_full > (gbs_pkg::STATE_W+2)'(gbs_pkg::MAG_MAX)) ?
               gbs_pkg::MAG_MAX : mag_full[gbs_pkg::MAG_W-1:0];

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    rd_en      = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take && frame_counted) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        rd_en = !issue_done;
        if (v2 && (b2 == LAST_BAND)) begin
          state_next = emit_pending ? S_E_RD : S_IDLE;
        end
      end
      S_E_RD: begin
        rd_en      = 1'b1;
        state_next = S_E_ABS;
      end
      S_E_ABS: begin
        state_next = S_E_OUT;
      end
      S_E_OUT: begin
        if (out_free) begin
          state_next = (b1 == LAST_BAND) ? S_IDLE : S_E_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      channel_count <= gbs_pkg::CHAN_STEREO;
      frame_index   <= FRAMES_END;
      band_valid    <= '0;
      emit_pending  <= 1'b0;
      rd_band       <= '0;
      issue_done    <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (config_write) begin
        channel_count <= config_data;
      end
      if (in_take) begin
        if (chunk_start) begin
          band_valid <= '0;
        end
        if (frame_counted) begin
          frame_index  <= frame_eff + 1'b1;
          emit_pending <= ((frame_eff + 1'b1) == FRAMES_END);
          rd_band      <= '0;
          issue_done   <= 1'b0;
        end else begin
          frame_index <= frame_eff;
        end
      end
      if (rd_en) begin
        if (rd_band == LAST_BAND) begin
          rd_band    <= '0;
          issue_done <= 1'b1;
        end else begin
          rd_band <= rd_band + 1'b1;
        end
      end
      v1 <= rd_en && (state == S_UPD);
      v2 <= v1;
      if (wr_en) begin
        band_valid[b2] <= 1'b1;
      end
      if (state == S_E_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      x <= mixed[gbs_pkg::SAMPLE_W-1 -: gbs_pkg::X_W];
    end
    if (rd_en) begin
      b1 <= rd_band;
    end
    b2 <= b1;
    if (v1) begin
      prod <= gbs_pkg::coef_of(b1) * $signed(rd_data.recent);
      s1_q <= rd_data.recent;
      s2_q <= rd_data.older;
    end
    if (state == S_E_ABS) begin
      abs1 <= rd_data.recent[gbs_pkg::STATE_W-1] ? (~rd_data.recent + 1'b1) :
              rd_data.recent;
      abs2 <= rd_data.older[gbs_pkg::STATE_W-1] ? (~rd_data.older + 1'b1) :
              rd_data.older;
    end
    if (state == S_E_OUT && out_free) begin
      band_index     <= gbs_pkg::IDX_W'(b1);
      band_magnitude <= mag;
      last_band      <= (b1 == LAST_BAND);
    end
  end

  // The write-back of a band never hits the entry being read in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (b2 != rd_band))
    else $error("state RAM read and write hit the same band");

  // The frame count never runs past the block length.
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    frame_index <= FRAMES_END)
    else $error("frame count beyond block length");

  // The output sweep only runs once a full block has been taken.
  a_emit_full_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_E_RD) |-> (frame_index == FRAMES_END))
    else $error("output sweep without a full block");

  // The last-band flag travels only with the highest band number.
  a_last_band_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_band) |-> (band_index == gbs_pkg::IDX_W'(gbs_pkg::NUM_BANDS - 1)))
    else $error("last band flag on the wrong band");

  // The RAM is written only during the update sweep.
  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_UPD))
    else $error("state RAM written outside the update sweep");

endmodule
